>>> hdl/drit_pkg.sv
// shared types, constants and codes for the delayed release id table
`timescale 1ns / 1ps

package drit_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = IDX_W + 1;
   localparam int ID_W        = 32;
   localparam int CTR_W       = 8;
   localparam int ENTRY_W     = ID_W + CTR_W;

   localparam logic [CTR_W-1:0] COUNTER_MAX     = 8'hFF;
   localparam logic [CTR_W-1:0] THRESHOLD_RESET = 8'd150;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_MOVE,
      ST_MISS
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CTR_W-1:0] ctr;
   } entry_type;

   typedef struct packed {
      logic             match;
      logic [CTR_W-1:0] bumped;
      logic             release_hit;
   } alu_out_type;

   typedef struct packed {
      logic             hit;
      logic             grant_event;
      logic             revoke_event;
      logic             table_full;
      logic [CTR_W-1:0] counter_after;
   } rsp_type;

endpackage

>>> hdl/drit_ram.sv
// generic single write port ram with registered, enabled read
`timescale 1ns / 1ps

module drit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/drit_alu.sv
// shared compare and counter unit: id match, saturating bump, threshold check
`timescale 1ns / 1ps

module drit_alu (
   input  drit_pkg::entry_type                entry,
   input  logic [drit_pkg::ID_W-1:0]          user_id,
   input  logic [drit_pkg::CTR_W-1:0]         threshold,
   output drit_pkg::alu_out_type              result
);

   logic [drit_pkg::CTR_W-1:0] bumped;

   always_comb begin
      if (entry.ctr == drit_pkg::COUNTER_MAX) begin
         bumped = drit_pkg::COUNTER_MAX;
      end else begin
         bumped = entry.ctr + drit_pkg::CTR_W'(1);
      end
      result.match       = (entry.id == user_id);
      result.bumped      = bumped;
      result.release_hit = (bumped >= threshold);
   end

endmodule

>>> hdl/drit_ctrl.sv
// sequencer: scans the entry ram one slot a cycle, then updates, appends or moves entries
`timescale 1ns / 1ps

module drit_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    op,
   input  logic [drit_pkg::ID_W-1:0]     user_id,
   input  logic [drit_pkg::CTR_W-1:0]    threshold,
   output logic                          busy,
   output logic                          rsp_strobe,
   output drit_pkg::rsp_type             rsp
);

   drit_pkg::state_type             state_ff, state_in;
   drit_pkg::op_type                op_ff, op_in;
   logic [drit_pkg::ID_W-1:0]       id_ff, id_in;
   logic [drit_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [drit_pkg::CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                            data_vld_ff, data_vld_in;
   logic [drit_pkg::IDX_W-1:0]      data_idx_ff, data_idx_in;
   logic [drit_pkg::IDX_W-1:0]      slot_ff, slot_in;
   drit_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            strobe_ff, strobe_in;

   logic                            wr_en;
   logic [drit_pkg::IDX_W-1:0]      wr_addr;
   drit_pkg::entry_type             wr_data;
   logic                            rd_en;
   logic [drit_pkg::IDX_W-1:0]      rd_addr;
   drit_pkg::entry_type             rd_data;
   drit_pkg::alu_out_type           alu;
   logic [drit_pkg::CNT_W-1:0]      last_idx;
   logic                            accept;

   drit_ram #(
      .WIDTH (drit_pkg::ENTRY_W),
      .DEPTH (drit_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   drit_alu u_alu (
      .entry     (rd_data),
      .user_id   (id_ff),
      .threshold (threshold),
      .result    (alu)
   );

   assign accept   = start && !busy;
   assign last_idx = count_ff - drit_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= drit_pkg::ST_IDLE;
         count_ff    <= '0;
         data_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         data_vld_ff <= data_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      scan_idx_ff <= scan_idx_in;
      data_idx_ff <= data_idx_in;
      slot_ff     <= slot_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      data_vld_in = 1'b0;
      data_idx_in = data_idx_ff;
      slot_in     = slot_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = '{id: id_ff, ctr: '0};
      rd_en       = 1'b0;
      rd_addr     = '0;

      case (state_ff)
         drit_pkg::ST_IDLE: begin
            if (accept) begin
               op_in  = drit_pkg::op_type'(op);
               id_in  = user_id;
               rsp_in = '0;
               if (drit_pkg::op_type'(op) == drit_pkg::OP_NOP) begin
                  strobe_in = 1'b1;
               end else if (drit_pkg::op_type'(op) == drit_pkg::OP_ADD &&
                            count_ff == drit_pkg::CNT_W'(drit_pkg::TABLE_DEPTH)) begin
                  rsp_in.table_full = 1'b1;
                  strobe_in         = 1'b1;
               end else if (count_ff == '0) begin
                  state_in = drit_pkg::ST_MISS;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  data_vld_in = 1'b1;
                  data_idx_in = '0;
                  scan_idx_in = drit_pkg::CNT_W'(1);
                  state_in    = drit_pkg::ST_SCAN;
               end
            end
         end
         drit_pkg::ST_SCAN: begin
            if (data_vld_ff && alu.match) begin
               // hold the ram output so the matched entry stays visible
               slot_in  = data_idx_ff;
               state_in = drit_pkg::ST_HIT;
            end else if (data_vld_ff &&
                         {1'b0, data_idx_ff} == last_idx) begin
               state_in = drit_pkg::ST_MISS;
            end else if (scan_idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff[drit_pkg::IDX_W-1:0];
               data_vld_in = 1'b1;
               data_idx_in = scan_idx_ff[drit_pkg::IDX_W-1:0];
               scan_idx_in = scan_idx_ff + drit_pkg::CNT_W'(1);
            end else begin
               state_in = drit_pkg::ST_MISS;
            end
         end
         drit_pkg::ST_HIT: begin
            rsp_in     = '0;
            rsp_in.hit = 1'b1;
            case (op_ff)
               drit_pkg::OP_ADD: begin
                  wr_en     = 1'b1;
                  strobe_in = 1'b1;
                  state_in  = drit_pkg::ST_IDLE;
               end
               drit_pkg::OP_QUERY: begin
                  wr_en                = 1'b1;
                  wr_data.ctr          = alu.bumped;
                  rsp_in.counter_after = alu.bumped;
                  strobe_in            = 1'b1;
                  state_in             = drit_pkg::ST_IDLE;
               end
               drit_pkg::OP_REMOVE: begin
                  rsp_in.counter_after = alu.bumped;
                  if (alu.release_hit) begin
                     // fetch the last entry to fill the freed slot
                     rsp_in.revoke_event = 1'b1;
                     rd_en               = 1'b1;
                     rd_addr             = last_idx[drit_pkg::IDX_W-1:0];
                     state_in            = drit_pkg::ST_MOVE;
                  end else begin
                     wr_en       = 1'b1;
                     wr_data.ctr = alu.bumped;
                     strobe_in   = 1'b1;
                     state_in    = drit_pkg::ST_IDLE;
                  end
               end
               default: begin
                  strobe_in = 1'b1;
                  state_in  = drit_pkg::ST_IDLE;
               end
            endcase
         end
         drit_pkg::ST_MOVE: begin
            wr_en     = 1'b1;
            wr_data   = rd_data;
            count_in  = last_idx;
            strobe_in = 1'b1;
            state_in  = drit_pkg::ST_IDLE;
         end
         drit_pkg::ST_MISS: begin
            rsp_in = '0;
            if (op_ff == drit_pkg::OP_ADD) begin
               wr_en              = 1'b1;
               wr_addr            = count_ff[drit_pkg::IDX_W-1:0];
               count_in           = count_ff + drit_pkg::CNT_W'(1);
               rsp_in.grant_event = 1'b1;
            end
            strobe_in = 1'b1;
            state_in  = drit_pkg::ST_IDLE;
         end
         default: begin
            state_in = drit_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != drit_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

>>> hdl/delayed_release_id_table_unit.sv
// top level of the delayed release id table: register port and sequencer
`timescale 1ns / 1ps

// channel   | handshake                         | payload
// ----------+-----------------------------------+-------------------------------------
// request   | start, busy (taken: start & !busy)| req_op, req_user_id
// result    | rsp_strobe, one cycle, no stall   | rsp_hit, rsp_grant_event,
//           |                                   | rsp_revoke_event, rsp_table_full,
//           |                                   | rsp_counter_after
// registers | psel, penable, pwrite, pready=1   | paddr, pwdata, prdata
//
// a request reads the stored entries one slot per cycle until its id matches or the
// last one is read, and a remove that drops its entry then moves the last entry into
// the freed slot; the bound is the entry ram with its single read port, feeding the
// shared compare unit. a full miss reads all sixteen stored entries.
// add on a full table and op code three are answered from idle, with no scan.
// busy stays high until the strobe cycle; a new request may be taken then.
// synchronous reset empties the table and sets the threshold to 150; the
// entry ram itself is not cleared, only entries below the fill count are read.
// the result side cannot stall: each result is shown for exactly one cycle.

module delayed_release_id_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [drit_pkg::ID_W-1:0]        req_user_id,
   // result channel
   output logic                             rsp_strobe,
   output logic                             rsp_hit,
   output logic                             rsp_grant_event,
   output logic                             rsp_revoke_event,
   output logic                             rsp_table_full,
   output logic [drit_pkg::CTR_W-1:0]       rsp_counter_after,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic [drit_pkg::CTR_W-1:0] threshold_ff, threshold_in;
   logic                       thr_sel;
   drit_pkg::rsp_type          rsp;

   // release_threshold is the only register, at byte address 0
   assign thr_sel = (paddr[2] == 1'b0);
   assign pready  = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      if (psel && penable && pwrite && thr_sel) begin
         threshold_in = pwdata[drit_pkg::CTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= drit_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // read back, unmapped addresses read zero
   always_comb begin
      prdata = '0;
      if (thr_sel) begin
         prdata = {{(32 - drit_pkg::CTR_W){1'b0}}, threshold_ff};
      end
   end

   // sequencer with entry ram and shared compare unit
   drit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_op),
      .user_id    (req_user_id),
      .threshold  (threshold_ff),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // unpack the result fields
   assign rsp_hit           = rsp.hit;
   assign rsp_grant_event   = rsp.grant_event;
   assign rsp_revoke_event  = rsp.revoke_event;
   assign rsp_table_full    = rsp.table_full;
   assign rsp_counter_after = rsp.counter_after;

endmodule

>>> test/tb_delayed_release_id_table_unit.sv
// self-checking testbench for the delayed release id table unit
`timescale 1ns / 1ps

module tb_delayed_release_id_table_unit;
   import drit_pkg::*;

   // threshold register is the only one, at byte address zero
   localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
   // longest quiet stretch of a correct run is a full scan plus the longest request gap
   localparam int WATCHDOG_LIMIT = 2000;
   // settle time after the last result, well over one full scan
   localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
   localparam int MAX_POOL       = 32;

   // tracks table contents and the results still owed by the block
   class id_table_tracker;
      logic [ID_W-1:0]  ids[TABLE_DEPTH];
      logic [CTR_W-1:0] ctrs[TABLE_DEPTH];
      int unsigned      fill;
      logic [CTR_W-1:0] threshold;
      rsp_type          owed_rsp[$];
      int unsigned      failures;
      int unsigned      requests, grants, revokes, rejects, hits, saturated;

      function new();
         fill      = 0;
         threshold = THRESHOLD_RESET;
         failures  = 0;
         requests  = 0;
         grants    = 0;
         revokes   = 0;
         rejects   = 0;
         hits      = 0;
         saturated = 0;
      endfunction

      // lowest slot holding the id, -1 when absent
      function int find_slot(logic [ID_W-1:0] id);
         for (int i = 0; i < fill; i++) begin
            if (ids[i] == id) return i;
         end
         return -1;
      endfunction

      // apply one accepted request and queue the result it must produce
      function void log_request(logic [1:0] op, logic [ID_W-1:0] id);
         rsp_type          r;
         int               slot;
         logic [CTR_W-1:0] c;
         r    = '0;
         slot = find_slot(id);
         requests++;
         case (op)
            OP_ADD: begin
               if (fill >= TABLE_DEPTH) begin
                  r.table_full = 1'b1;
               end else if (slot >= 0) begin
                  r.hit      = 1'b1;
                  ctrs[slot] = '0;
               end else begin
                  ids[fill]     = id;
                  ctrs[fill]    = '0;
                  fill++;
                  r.grant_event = 1'b1;
               end
            end
            OP_QUERY, OP_REMOVE: begin
               if (slot >= 0) begin
                  c = (ctrs[slot] == COUNTER_MAX) ? COUNTER_MAX : ctrs[slot] + 8'd1;
                  r.hit           = 1'b1;
                  r.counter_after = c;
                  if (c == COUNTER_MAX) saturated++;
                  if (op == OP_REMOVE && c >= threshold) begin
                     // last entry fills the freed slot
                     ids[slot]      = ids[fill-1];
                     ctrs[slot]     = ctrs[fill-1];
                     fill--;
                     r.revoke_event = 1'b1;
                  end else begin
                     ctrs[slot] = c;
                  end
               end
            end
            default: ;
         endcase
         if (r.hit) hits++;
         if (r.grant_event) grants++;
         if (r.revoke_event) revokes++;
         if (r.table_full) rejects++;
         owed_rsp.push_back(r);
      endfunction

      // compare one strobed result with the oldest one owed
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            $error("result strobe with no request outstanding");
            failures++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            failures++;
         end
         if (got.grant_event !== want.grant_event) begin
            $error("grant_event: expected %0d, actual %0d", want.grant_event,
                   got.grant_event);
            failures++;
         end
         if (got.revoke_event !== want.revoke_event) begin
            $error("revoke_event: expected %0d, actual %0d", want.revoke_event,
                   got.revoke_event);
            failures++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d", want.table_full,
                   got.table_full);
            failures++;
         end
         if (got.counter_after !== want.counter_after) begin
            $error("counter_after: expected %0d, actual %0d", want.counter_after,
                   got.counter_after);
            failures++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_op;
   logic [ID_W-1:0]     req_user_id;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic                rsp_grant_event;
   logic                rsp_revoke_event;
   logic                rsp_table_full;
   logic [CTR_W-1:0]    rsp_counter_after;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   id_table_tracker     id_model = new();
   bit                  no_gaps;
   int unsigned         threshold_writes;
   int unsigned         quiet_cycles = 0;

   delayed_release_id_table_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_user_id       (req_user_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_grant_event   (rsp_grant_event),
      .rsp_revoke_event  (rsp_revoke_event),
      .rsp_table_full    (rsp_table_full),
      .rsp_counter_after (rsp_counter_after),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // monitor: values read here are the ones the block saw at this edge,
   // since everything is driven with nonblocking assignments at the edge.
   // the request is logged before the result check; a result shown in the cycle
   // that accepts the next request still pops its own, older expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) id_model.log_request(req_op, req_user_id);
         if (rsp_strobe) begin
            id_model.check_result(rsp_type'({rsp_hit, rsp_grant_event, rsp_revoke_event,
                                             rsp_table_full, rsp_counter_after}));
         end
      end
   end

   // watchdog: counts cycles with no request, result or register access
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // present one request and hold it until the block takes it; start stays
   // high straight into the next request when no gap is drawn
   task automatic issue(op_type op, logic [ID_W-1:0] id);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_user_id <= id;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // drop start and wait until every owed result has come back
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (id_model.owed_rsp.size() != 0);
   endtask

   // read the threshold register and compare its low byte
   task automatic csr_readback();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= THRESHOLD_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[CTR_W-1:0] !== id_model.threshold) begin
         $error("release_threshold: expected %0d, actual %0d", id_model.threshold,
                prdata[CTR_W-1:0]);
         id_model.failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // new threshold between phases, with random upper data bits
   task automatic set_threshold(logic [CTR_W-1:0] value);
      logic [31:0] wdata;
      wdata        = $urandom();
      wdata[7:0]   = value;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= THRESHOLD_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      id_model.threshold = value;
      threshold_writes++;
      csr_readback();
   endtask

   // random traffic over a small id pool so adds, hits, drops and a full
   // table all keep happening; a tenth of the ids are fresh random misses
   task automatic random_phase(int unsigned n_items, int unsigned pool_size);
      logic [ID_W-1:0] pool[MAX_POOL];
      logic [ID_W-1:0] id;
      int unsigned     pick;
      op_type          op;
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom();
      if ($urandom_range(0, 1)) pool[0] = '0;
      if ($urandom_range(0, 1)) pool[pool_size-1] = '1;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      op = OP_ADD;
         else if (pick < 60) op = OP_QUERY;
         else if (pick < 96) op = OP_REMOVE;
         else                op = OP_NOP;
         if ($urandom_range(0, 9) == 0) id = $urandom();
         else                           id = pool[$urandom_range(0, pool_size - 1)];
         issue(op, id);
      end
   endtask

   initial begin
      logic [ID_W-1:0]  fill_id;
      logic [ID_W-1:0]  sat_id;
      logic [CTR_W-1:0] phase_thr[10];

      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_NOP;
      req_user_id      = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      no_gaps          = 1'b0;
      threshold_writes = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold comes out of reset at 150
      csr_readback();

      // nop, misses on an empty table, extreme ids
      issue(OP_NOP, '0);
      issue(OP_QUERY, '0);
      issue(OP_REMOVE, '1);
      // two grants, then add of a present id only clears its counter
      issue(OP_ADD, '0);
      issue(OP_ADD, '1);
      issue(OP_ADD, '0);
      issue(OP_QUERY, '1);
      issue(OP_REMOVE, '0);
      issue(OP_ADD, '0);
      // fill the table, then add is rejected even for a present id
      for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
         fill_id = $urandom();
         issue(OP_ADD, fill_id);
      end
      issue(OP_ADD, 32'h5A5A_A5A5);
      issue(OP_ADD, '0);

      // low threshold: a query above it never drops, a remove does and the
      // last entry moves into the freed slot
      set_threshold(8'd1);
      issue(OP_QUERY, '1);
      issue(OP_REMOVE, '1);
      issue(OP_QUERY, fill_id);
      issue(OP_REMOVE, fill_id);
      // threshold of zero: first remove always drops
      set_threshold(8'd0);
      issue(OP_REMOVE, '0);
      issue(OP_QUERY, '0);

      // counter saturation at the top threshold
      set_threshold(8'd255);
      sat_id  = $urandom();
      no_gaps = 1'b1;
      issue(OP_ADD, sat_id);
      repeat (100) issue(OP_QUERY, sat_id);
      no_gaps = 1'b0;
      repeat (157) issue(OP_QUERY, sat_id);
      issue(OP_REMOVE, sat_id);

      // random phases across a spread of thresholds, extremes included
      phase_thr = '{8'd2, 8'd3, 8'd1, 8'd5, THRESHOLD_RESET, 8'd0, 8'd255, 8'd8,
                    8'd0, 8'd1};
      phase_thr[8] = $urandom_range(1, 255);
      foreach (phase_thr[p]) begin
         set_threshold(phase_thr[p]);
         random_phase(140, $urandom_range(4, 24));
      end

      // drain and let any stray result show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d threshold settings", id_model.requests,
               threshold_writes);
      $display("grants %0d, revokes %0d, full rejects %0d, hits %0d, saturated %0d",
               id_model.grants, id_model.revokes, id_model.rejects, id_model.hits,
               id_model.saturated);
      if (id_model.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/drit_pkg.sv
hdl/drit_ram.sv
hdl/drit_alu.sv
hdl/drit_ctrl.sv
hdl/delayed_release_id_table_unit.sv
test/tb_delayed_release_id_table_unit.sv
